// File: rtl/vxe_pkg.sv
// Shared types, constants and register codes of the VXLAN encapsulator.
package vxe_pkg;

   // Outer header length in bytes, and the width of a position within it.
   localparam int HDR_LEN = 50;
   localparam int HDR_AW = $clog2(HDR_LEN);
   localparam int HDR_CW = $clog2(HDR_LEN + 1);

   // Largest inner length written into the outer length fields.
   localparam int MAX_FRAME = 9216;

   // Output queue geometry.
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW = $clog2(OQ_DEPTH);
   localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

   // Configuration register indexes.
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_SOURCE_MAC = 2'd0;
   localparam reg_index_type REG_DESTINATION_MAC = 2'd1;
   localparam reg_index_type REG_NETWORK_ID = 2'd2;
   localparam reg_index_type REG_TUNNEL_PORT = 2'd3;

   // Register reset values.
   localparam logic [47:0] SOURCE_MAC_RST = 48'hDEED_BEEF_ABCD;
   localparam logic [47:0] DESTINATION_MAC_RST = 48'h1070_FDC8_9475;
   localparam logic [23:0] NETWORK_ID_RST = 24'h12_3456;
   localparam logic [15:0] TUNNEL_PORT_RST = 16'd4789;

   // Configuration registers as seen by the header generator.
   typedef struct packed {
      logic [47:0] source_mac;
      logic [47:0] destination_mac;
      logic [23:0] network_id;
      logic [15:0] tunnel_port;
   } cfg_type;

   // One output word: a byte and its end-of-frame marker.
   typedef struct packed {
      logic [7:0] byte_val;
      logic       end_flag;
   } out_word_type;

   // Sequencer states: streaming inner bytes or flushing the delay line.
   typedef enum logic {
      ST_STREAM,
      ST_FLUSH
   } seq_state_type;

endpackage

// File: rtl/vxlan_encapsulator.sv
// VXLAN encapsulator top level: sequencer, delay-line RAM, header generator and output queue.
// Inner frame bytes arrive one per cycle while req_ready is high, and each accepted byte
// yields one result word: one of the 50 outer header bytes while the frame is young, and
// afterwards the inner byte that arrived 50 bytes earlier, read from a 50-entry delay-line
// RAM written and read at the same slot for each accepted byte. The byte marked frame_end
// starts a flush of 50 more words, one per cycle while the output queue has room, during
// which req_ready is low. A result word passes through the RAM read with its pipeline
// register, then the output queue, before it can be taken on the rsp port, and the
// four-entry output queue keeps the input running while a result waits to be taken. Every
// delay-line entry is written before its contents reach the output, so the RAM needs no
// clearing after reset. The configuration registers may be written only while no frame is
// in flight.
module vxlan_encapsulator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   input  logic [13:0] req_frame_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_end,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   localparam int HDR_AW = vxe_pkg::HDR_AW;
   localparam int HDR_CW = vxe_pkg::HDR_CW;

   vxe_pkg::cfg_type        cfg_ff, cfg_in;
   vxe_pkg::seq_state_type  state_ff, state_in;
   logic [HDR_CW-1:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [HDR_AW-1:0]       slot_ff, slot_in;
   logic [HDR_AW-1:0]       flush_cnt_ff, flush_cnt_in;
   logic [13:0]             held_ff, held_in;
   logic                    s1_valid_ff;
   logic                    s1_sel_ram_ff;
   logic [7:0]              s1_hdr_ff;
   logic                    s1_end_ff;

   logic                    room;
   logic                    accept;
   logic                    issue;
   logic                    issue_end;
   logic                    in_hdr;
   logic [7:0]              hdr_inner;
   logic [7:0]              hdr_byte;
   logic [7:0]              ram_q;
   logic [vxe_pkg::OQ_CW-1:0] q_count;
   vxe_pkg::out_word_type   push_word;
   vxe_pkg::out_word_type   q_word;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            vxe_pkg::REG_SOURCE_MAC:      cfg_in.source_mac = csr_data;
            vxe_pkg::REG_DESTINATION_MAC: cfg_in.destination_mac = csr_data;
            vxe_pkg::REG_NETWORK_ID:      cfg_in.network_id = csr_data[23:0];
            vxe_pkg::REG_TUNNEL_PORT:     cfg_in.tunnel_port = csr_data[15:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_mac <= vxe_pkg::SOURCE_MAC_RST;
         cfg_ff.destination_mac <= vxe_pkg::DESTINATION_MAC_RST;
         cfg_ff.network_id <= vxe_pkg::NETWORK_ID_RST;
         cfg_ff.tunnel_port <= vxe_pkg::TUNNEL_PORT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Issue only when the queue can take everything already in the pipeline plus this word.
   assign room = (q_count + vxe_pkg::OQ_CW'(s1_valid_ff)) < vxe_pkg::OQ_CW'(vxe_pkg::OQ_DEPTH);
   assign req_ready = (state_ff == vxe_pkg::ST_STREAM) && room;
   assign accept = req_valid && req_ready;
   assign in_hdr = hdr_cnt_ff < HDR_CW'(vxe_pkg::HDR_LEN);
   assign hdr_inner = (state_ff == vxe_pkg::ST_STREAM) ? req_data_byte : 8'h00;

   // Sequencer: next state, position counters and held length.
   always_comb begin
      state_in = state_ff;
      hdr_cnt_in = hdr_cnt_ff;
      slot_in = slot_ff;
      flush_cnt_in = flush_cnt_ff;
      held_in = held_ff;
      issue = 1'b0;
      issue_end = 1'b0;

      unique case (state_ff)
         vxe_pkg::ST_STREAM: begin
            issue = accept;
            if (accept && (hdr_cnt_ff == '0)) begin
               held_in = (32'(req_frame_length) > vxe_pkg::MAX_FRAME) ?
                         14'(vxe_pkg::MAX_FRAME) : req_frame_length;
            end
            if (accept && req_frame_end) begin
               state_in = vxe_pkg::ST_FLUSH;
               flush_cnt_in = '0;
            end
         end
         vxe_pkg::ST_FLUSH: begin
            issue = room;
            if (room) begin
               flush_cnt_in = flush_cnt_ff + 1'b1;
               if (flush_cnt_ff == HDR_AW'(vxe_pkg::HDR_LEN - 1)) begin
                  issue_end = 1'b1;
                  state_in = vxe_pkg::ST_STREAM;
               end
            end
         end
         default: state_in = vxe_pkg::ST_STREAM;
      endcase

      // Every issued word advances the delay-line slot, and the header position while in the header.
      if (issue) begin
         if (in_hdr) begin
            hdr_cnt_in = hdr_cnt_ff + 1'b1;
         end
         slot_in = (slot_ff == HDR_AW'(vxe_pkg::HDR_LEN - 1)) ? '0 : slot_ff + 1'b1;
      end
      if (issue_end) begin
         hdr_cnt_in = '0;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vxe_pkg::ST_STREAM;
         hdr_cnt_ff <= '0;
         slot_ff <= '0;
         flush_cnt_ff <= '0;
         held_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hdr_cnt_ff <= hdr_cnt_in;
         slot_ff <= slot_in;
         flush_cnt_ff <= flush_cnt_in;
         held_ff <= held_in;
         s1_valid_ff <= issue;
      end
   end

   // Pipeline register that waits alongside the RAM read.
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_sel_ram_ff <= !in_hdr;
         s1_hdr_ff <= hdr_byte;
         s1_end_ff <= issue_end;
      end
   end

   vxe_hdr u_hdr (
      .cfg         (cfg_ff),
      .held_length (held_ff),
      .idx         (hdr_cnt_ff),
      .inner_byte  (hdr_inner),
      .hdr_byte    (hdr_byte)
   );

   // Delay line: the incoming byte replaces the one that arrived 50 bytes ago, read out as it is replaced.
   vxe_ram #(
      .WIDTH (8),
      .DEPTH (vxe_pkg::HDR_LEN)
   ) u_delay (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_data_byte),
      .rd_en   (issue),
      .rd_addr (slot_ff),
      .rd_data (ram_q)
   );

   assign push_word.byte_val = s1_sel_ram_ff ? ram_q : s1_hdr_ff;
   assign push_word.end_flag = s1_end_ff;

   vxe_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_word  (push_word),
      .pop        (rsp_ready),
      .out_valid  (rsp_valid),
      .out_word   (q_word),
      .count      (q_count)
   );

   assign rsp_out_byte = q_word.byte_val;
   assign rsp_out_end = q_word.end_flag;

endmodule

// File: rtl/vxe_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module vxe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 50,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read and a write to the same entry in one cycle return the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vxe_hdr.sv
// Outer Ethernet, IPv4, UDP and VXLAN header byte generator.
module vxe_hdr (
   input  vxe_pkg::cfg_type          cfg,
   input  logic [13:0]               held_length,
   input  logic [vxe_pkg::HDR_CW-1:0] idx,
   input  logic [7:0]                inner_byte,
   output logic [7:0]                hdr_byte
);

   logic [15:0] total_length;
   logic [15:0] udp_length;

   // Length fields cover the inner frame plus the outer headers after them.
   assign total_length = 16'(held_length) + 16'd36;
   assign udp_length = 16'(held_length) + 16'd16;

   // Byte selection by header offset; everything not listed is zero.
   always_comb begin
      case (idx) inside
         6'd0:  hdr_byte = cfg.destination_mac[47:40];
         6'd1:  hdr_byte = cfg.destination_mac[39:32];
         6'd2:  hdr_byte = cfg.destination_mac[31:24];
         6'd3:  hdr_byte = cfg.destination_mac[23:16];
         6'd4:  hdr_byte = cfg.destination_mac[15:8];
         6'd5:  hdr_byte = cfg.destination_mac[7:0];
         6'd6:  hdr_byte = cfg.source_mac[47:40];
         6'd7:  hdr_byte = cfg.source_mac[39:32];
         6'd8:  hdr_byte = cfg.source_mac[31:24];
         6'd9:  hdr_byte = cfg.source_mac[23:16];
         6'd10: hdr_byte = cfg.source_mac[15:8];
         6'd11: hdr_byte = cfg.source_mac[7:0];
         6'd12: hdr_byte = 8'h08;
         6'd14: hdr_byte = 8'h45;
         6'd16: hdr_byte = total_length[15:8];
         6'd17: hdr_byte = total_length[7:0];
         6'd23: hdr_byte = 8'd17;
         // Outer addresses and source port sit at the same offsets as the inner ones.
         [6'd26:6'd35]: hdr_byte = inner_byte;
         6'd36: hdr_byte = cfg.tunnel_port[15:8];
         6'd37: hdr_byte = cfg.tunnel_port[7:0];
         6'd38: hdr_byte = udp_length[15:8];
         6'd39: hdr_byte = udp_length[7:0];
         6'd42: hdr_byte = 8'h08;
         6'd46: hdr_byte = cfg.network_id[23:16];
         6'd47: hdr_byte = cfg.network_id[15:8];
         6'd48: hdr_byte = cfg.network_id[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

endmodule

// File: rtl/vxe_outq.sv
// Small output queue that decouples the result port from the pipeline.
module vxe_outq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  vxe_pkg::out_word_type      push_word,
   input  logic                       pop,
   output logic                       out_valid,
   output vxe_pkg::out_word_type      out_word,
   output logic [vxe_pkg::OQ_CW-1:0]  count
);

   vxe_pkg::out_word_type            entries_ff [vxe_pkg::OQ_DEPTH];
   logic [vxe_pkg::OQ_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [vxe_pkg::OQ_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [vxe_pkg::OQ_CW-1:0]        count_ff, count_in;
   logic                             pop_eff;

   assign out_valid = (count_ff != '0);
   assign out_word = entries_ff[rd_ptr_ff];
   assign count = count_ff;
   assign pop_eff = pop && out_valid;

   // Pointer and occupancy update; the producer never pushes into a full queue.
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_eff ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + vxe_pkg::OQ_CW'(push_valid) - vxe_pkg::OQ_CW'(pop_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: rtl/vxe_checker.sv
// Port-level checks for the VXLAN encapsulator and their binding to the top level.
module vxe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_frame_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_end
);

   // A word that is not taken stays offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_end))
      else $error("result word changed while stalled");

   // The last inner byte starts a flush, so the input must close at once.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_end |=> !req_ready)
      else $error("input accepted right after a frame end");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An end-marked word leaving means the flush has ended or is ending; no two ends in a row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_out_end |=> !(rsp_valid && rsp_out_end))
      else $error("two consecutive end-of-frame words");

endmodule

bind vxlan_encapsulator vxe_checker u_vxe_checker (.*);
